// ===== rtl/core/swd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swd_pkg: shared types and constants for the swipe direction classifier
// Op, direction and register codes, the control word layout and the
// microcode program that drives the end-of-swipe classification.
// ----------------------------------------------------------------------------
package swd_pkg;

    // Field widths fixed by the interface
    localparam int OP_W     = 2;
    localparam int FINGER_W = 4;
    localparam int DELTA_W  = 16;
    localparam int DIR_W    = 2;
    localparam int CMD_W    = 3;
    localparam int THRESH_W = 23;
    localparam int RATIO_W  = 16;
    localparam int CFG_IDX_W = 2;

    // Ratio is Q0.16, so the squares are scaled by 2^16 before comparing
    localparam int FRAC_W  = 16;
    // Multiplier consumes one 8-bit digit per step
    localparam int DIGIT_W = 8;
    // r has two digits
    localparam int RATIO_DIGITS = RATIO_W / DIGIT_W;

    // Input op codes
    localparam logic [OP_W-1:0] OP_BEGIN  = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OP_END    = 2'd2;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

    // Command codes: no command, else direction plus one
    localparam logic [CMD_W-1:0] CMD_NONE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_BASE = 3'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FINGERS = 2'd2;

    // Reset values of the configuration registers
    localparam logic [THRESH_W-1:0] THRESH_RST  = 23'd25600;
    localparam logic [RATIO_W-1:0]  RATIO_RST   = 16'd27146;
    localparam logic [FINGER_W-1:0] FINGERS_RST = 4'd3;

    // Program addresses
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_CHECK   = 4'd0;
    localparam logic [PC_W-1:0] PC_MUL_XX  = 4'd1;
    localparam logic [PC_W-1:0] PC_SAVE_A  = 4'd2;
    localparam logic [PC_W-1:0] PC_MUL_YY  = 4'd3;
    localparam logic [PC_W-1:0] PC_SAVE_B  = 4'd4;
    localparam logic [PC_W-1:0] PC_MUL_XY  = 4'd5;
    localparam logic [PC_W-1:0] PC_LOAD_CR = 4'd6;
    localparam logic [PC_W-1:0] PC_MUL_CR  = 4'd7;
    localparam logic [PC_W-1:0] PC_RHS     = 4'd8;
    localparam logic [PC_W-1:0] PC_DECIDE  = 4'd9;

    // Multiplier operand selection
    typedef enum logic [2:0] {
        LD_NONE,
        LD_XX,
        LD_YY,
        LD_XY,
        LD_CR
    } mul_load_t;

    // Classification done by a step
    typedef enum logic [1:0] {
        DEC_NONE,
        DEC_THRESH,
        DEC_RATIO
    } decide_t;

    // Step counter control
    typedef enum logic [1:0] {
        J_NEXT,
        J_LOOP,
        J_BYPASS,
        J_END
    } jump_t;

    // One control word
    typedef struct packed {
        mul_load_t mul_load;
        logic      step;
        logic      store_a;
        logic      store_b;
        logic      form_rhs;
        decide_t   decide;
        jump_t     jump;
    } ucode_t;

    // Multiplier control from the sequencer
    typedef struct packed {
        logic load;
        logic step;
    } mul_ctl_t;

    // Microcode program ROM
    function automatic ucode_t ucode_word(input logic [PC_W-1:0] pc);
        ucode_t w;
        begin
            w          = '0;
            w.mul_load = LD_NONE;
            w.decide   = DEC_NONE;
            w.jump     = J_NEXT;
            case (pc)
                PC_CHECK:
                begin
                    w.decide   = DEC_THRESH;
                    w.mul_load = LD_XX;
                    w.jump     = J_BYPASS;
                end
                PC_MUL_XX, PC_MUL_YY, PC_MUL_XY, PC_MUL_CR:
                begin
                    w.step = 1'b1;
                    w.jump = J_LOOP;
                end
                PC_SAVE_A:
                begin
                    w.store_a  = 1'b1;
                    w.mul_load = LD_YY;
                end
                PC_SAVE_B:
                begin
                    w.store_b  = 1'b1;
                    w.mul_load = LD_XY;
                end
                PC_LOAD_CR:
                begin
                    w.mul_load = LD_CR;
                end
                PC_RHS:
                begin
                    w.form_rhs = 1'b1;
                end
                PC_DECIDE:
                begin
                    w.decide = DEC_RATIO;
                    w.jump   = J_END;
                end
                default:
                begin
                    w.jump = J_END;
                end
            endcase
            return w;
        end
    endfunction

endpackage

// ===== rtl/core/swd_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swd_mul: digit-serial multiplier
// Multiplies a wide multiplicand by an operand one 8-bit digit per step,
// accumulating into a wide register. Load sets operands and step count.
// ----------------------------------------------------------------------------
module swd_mul
    import swd_pkg::*;
#(
    parameter int OPW  = 24,
    parameter int ACCW = 64,
    parameter int CNTW = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  mul_ctl_t        ctl,
    input  logic [ACCW-1:0] mcand,
    input  logic [OPW-1:0]  mplier,
    input  logic [CNTW-1:0] cnt,
    output logic [ACCW-1:0] acc,
    output logic            more
);

    logic [ACCW-1:0] mcand_reg;
    logic [OPW-1:0]  mplier_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [ACCW-1:0] acc_reg;
    logic [ACCW-1:0] pp;

    // partial product of the current low digit
    assign pp = mcand_reg * {{(ACCW-DIGIT_W){1'b0}}, mplier_reg[DIGIT_W-1:0]};

    // step count: control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.load)
        begin
            cnt_reg <= cnt;
        end
        else if (ctl.step && (cnt_reg != '0))
        begin
            cnt_reg <= cnt_reg - {{(CNTW-1){1'b0}}, 1'b1};
        end
    end

    // operands and accumulator
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            mcand_reg  <= mcand;
            mplier_reg <= mplier;
            acc_reg    <= '0;
        end
        else if (ctl.step)
        begin
            acc_reg    <= acc_reg + pp;
            mcand_reg  <= mcand_reg << DIGIT_W;
            mplier_reg <= mplier_reg >> DIGIT_W;
        end
    end

    assign acc  = acc_reg;
    assign more = (cnt_reg != '0);

endmodule

// ===== rtl/core/swipe_direction_classifier_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swipe_direction_classifier_top: touchpad swipe classifier
// Accumulates saturating motion sums between gesture begin and end, then
// classifies the swipe with a microcoded sequencer over a shared multiplier.
// ----------------------------------------------------------------------------
// Begin and update words may follow back to back while no end word is being classified.
// An end word holds the input off until the threshold alone decides, or
// until the oblique ratio test has run when both sums reach the threshold;
// the 8-bit digit-serial multiplier carries that test.
// The result word is valid the cycle after the deciding step.
// Reset (rst_n, asynchronous) clears sums, latched fingers and sequencer and
// loads the default threshold, ratio and command finger count.
module swipe_direction_classifier_top
    import swd_pkg::*;
#(
    parameter int SUM_WIDTH = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [THRESH_W-1:0]  cfg_data,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,  // finger_count[3:0], delta_x[19:4], delta_y[35:20]
    input  logic [OP_W-1:0]      s_tuser,  // op[1:0]
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata   // direction[1:0], fingers[5:2], command[8:6]
);

    localparam int W     = SUM_WIDTH;
    localparam int MW    = 2 * SUM_WIDTH;
    localparam int PW    = MW + FRAC_W;
    localparam int CMP_W = (SUM_WIDTH > THRESH_W) ? SUM_WIDTH : THRESH_W;
    localparam int NDIG  = (SUM_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int CNT_W = $clog2(NDIG);

    // configuration
    logic [THRESH_W-1:0] thr_reg;
    logic [RATIO_W-1:0]  ratio_reg;
    logic [FINGER_W-1:0] cmd_fingers_reg;

    // gesture state
    logic [W-1:0]        sum_x_reg, sum_x_next;
    logic [W-1:0]        sum_y_reg, sum_y_next;
    logic [FINGER_W-1:0] latched_reg;

    // sequencer
    logic                busy_reg, busy_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    ucode_t              cw;
    logic                stall, adv;

    // classification datapath
    logic [W-1:0]        ax_reg, ay_reg;
    logic                x_pos_reg, y_pos_reg;
    logic [MW-1:0]       sq_a_reg, sq_b_reg;
    logic [PW-1:0]       rh_x_reg, rh_y_reg;

    // result register
    logic                m_tvalid_reg;
    logic [DIR_W-1:0]    out_dir_reg;
    logic [FINGER_W-1:0] out_fingers_reg;
    logic [CMD_W-1:0]    out_cmd_reg;

    // multiplier
    mul_ctl_t            mctl;
    logic [PW-1:0]       m_mcand;
    logic [W-1:0]        m_mplier;
    logic [CNT_W-1:0]    m_cnt;
    logic [PW-1:0]       m_acc;
    logic                m_more;

    logic                in_acc;
    logic [OP_W-1:0]     in_op;
    logic [FINGER_W-1:0] in_fingers;
    logic [DELTA_W-1:0]  in_dx, in_dy;

    logic                both_ge, ax_gt, ay_gt;
    logic                horiz, vert;
    logic                emit_want, emitting;
    logic [DIR_W-1:0]    emit_dir;
    logic [CMD_W-1:0]    emit_cmd;

    // ------------------------------------------------------------------
    // input word unpacking
    assign in_acc     = s_tvalid && s_tready;
    assign in_op      = s_tuser;
    assign in_fingers = s_tdata[3:0];
    assign in_dx      = s_tdata[19:4];
    assign in_dy      = s_tdata[35:20];
    assign s_tready   = !busy_reg;

    // saturating add of a Q8.8 delta to a sum
    function automatic logic [W-1:0] sat_add(input logic [W-1:0] s,
                                             input logic [DELTA_W-1:0] d);
        logic [W:0] t;
        begin
            t = {s[W-1], s} + {{(W+1-DELTA_W){d[DELTA_W-1]}}, d};
            if (t[W] != t[W-1])
            begin
                return t[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end
            return t[W-1:0];
        end
    endfunction

    // magnitude; the most negative sum maps to 2^(W-1), still W bits
    function automatic logic [W-1:0] mag(input logic [W-1:0] s);
        begin
            return s[W-1] ? (~s) + {{(W-1){1'b0}}, 1'b1} : s;
        end
    endfunction

    // next sums
    always_comb
    begin
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        if (in_acc)
        begin
            case (in_op)
                OP_BEGIN, OP_END:
                begin
                    sum_x_next = '0;
                    sum_y_next = '0;
                end
                OP_UPDATE:
                begin
                    sum_x_next = sat_add(sum_x_reg, in_dx);
                    sum_y_next = sat_add(sum_y_reg, in_dy);
                end
                default:
                begin
                    sum_x_next = sum_x_reg;
                    sum_y_next = sum_y_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // threshold and ratio tests
    assign both_ge = (CMP_W'(ax_reg) >= CMP_W'(thr_reg)) &&
                     (CMP_W'(ay_reg) >= CMP_W'(thr_reg));
    assign ax_gt   = CMP_W'(ax_reg) > CMP_W'(thr_reg);
    assign ay_gt   = CMP_W'(ay_reg) > CMP_W'(thr_reg);
    assign horiz   = {sq_a_reg, {FRAC_W{1'b0}}} > rh_x_reg;
    assign vert    = {sq_b_reg, {FRAC_W{1'b0}}} > rh_y_reg;

    // control word and result selection
    assign cw = ucode_word(pc_reg);

    always_comb
    begin
        emit_want = 1'b0;
        emit_dir  = DIR_UP;
        case (cw.decide)
            DEC_THRESH:
            begin
                emit_want = !both_ge && (ax_gt || ay_gt);
                if (ax_gt)
                begin
                    emit_dir = x_pos_reg ? DIR_RIGHT : DIR_LEFT;
                end
                else
                begin
                    emit_dir = y_pos_reg ? DIR_DOWN : DIR_UP;
                end
            end
            DEC_RATIO:
            begin
                emit_want = horiz || vert;
                if (horiz)
                begin
                    emit_dir = x_pos_reg ? DIR_RIGHT : DIR_LEFT;
                end
                else
                begin
                    emit_dir = y_pos_reg ? DIR_DOWN : DIR_UP;
                end
            end
            default:
            begin
                emit_want = 1'b0;
                emit_dir  = DIR_UP;
            end
        endcase
    end

    assign emit_cmd = (latched_reg == cmd_fingers_reg) ?
                      ({1'b0, emit_dir} + CMD_BASE) : CMD_NONE;

    // hold the deciding step while the result register is still occupied
    assign stall    = busy_reg && emit_want && m_tvalid_reg && !m_tready;
    assign adv      = busy_reg && !stall;
    assign emitting = adv && emit_want;

    // step counter and jumps
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (in_acc && (in_op == OP_END))
        begin
            busy_next = 1'b1;
            pc_next   = PC_CHECK;
        end
        else if (adv)
        begin
            case (cw.jump)
                J_NEXT:
                begin
                    pc_next = pc_reg + {{(PC_W-1){1'b0}}, 1'b1};
                end
                J_LOOP:
                begin
                    if (!m_more)
                    begin
                        pc_next = pc_reg + {{(PC_W-1){1'b0}}, 1'b1};
                    end
                end
                J_BYPASS:
                begin
                    if (both_ge)
                    begin
                        pc_next = pc_reg + {{(PC_W-1){1'b0}}, 1'b1};
                    end
                    else
                    begin
                        busy_next = 1'b0;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // multiplier operand selection
    always_comb
    begin
        mctl.load = adv && (cw.mul_load != LD_NONE);
        mctl.step = adv && cw.step;
        m_mcand   = PW'(ax_reg);
        m_mplier  = ax_reg;
        m_cnt     = CNT_W'(NDIG - 1);
        case (cw.mul_load)
            LD_YY:
            begin
                m_mcand  = PW'(ay_reg);
                m_mplier = ay_reg;
            end
            LD_XY:
            begin
                m_mcand  = PW'(ax_reg);
                m_mplier = ay_reg;
            end
            LD_CR:
            begin
                m_mcand  = PW'(m_acc[MW-1:0]);
                m_mplier = W'(ratio_reg);
                m_cnt    = CNT_W'(RATIO_DIGITS - 1);
            end
            default:
            begin
                m_mcand  = PW'(ax_reg);
                m_mplier = ax_reg;
            end
        endcase
    end

    swd_mul #(
        .OPW  (W),
        .ACCW (PW),
        .CNTW (CNT_W)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mctl),
        .mcand  (m_mcand),
        .mplier (m_mplier),
        .cnt    (m_cnt),
        .acc    (m_acc),
        .more   (m_more)
    );

    // ------------------------------------------------------------------
    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg         <= THRESH_RST;
            ratio_reg       <= RATIO_RST;
            cmd_fingers_reg <= FINGERS_RST;
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
            latched_reg     <= '0;
            busy_reg        <= 1'b0;
            pc_reg          <= PC_CHECK;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_THRESH:  thr_reg         <= cfg_data;
                    REG_RATIO:   ratio_reg       <= cfg_data[RATIO_W-1:0];
                    REG_FINGERS: cmd_fingers_reg <= cfg_data[FINGER_W-1:0];
                    default:     thr_reg         <= thr_reg;
                endcase
            end
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            if (in_acc && (in_op == OP_BEGIN))
            begin
                latched_reg <= in_fingers;
            end
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            // result handshake
            if (emitting)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        // snapshot magnitudes and signs at gesture end
        if (in_acc && (in_op == OP_END))
        begin
            ax_reg    <= mag(sum_x_reg);
            ay_reg    <= mag(sum_y_reg);
            x_pos_reg <= !sum_x_reg[W-1] && (sum_x_reg != '0);
            y_pos_reg <= !sum_y_reg[W-1] && (sum_y_reg != '0);
        end
        if (adv && cw.store_a)
        begin
            sq_a_reg <= m_acc[MW-1:0];
        end
        if (adv && cw.store_b)
        begin
            sq_b_reg <= m_acc[MW-1:0];
        end
        // right-hand sides: other square scaled plus r times cross product
        if (adv && cw.form_rhs)
        begin
            rh_x_reg <= {sq_b_reg, {FRAC_W{1'b0}}} + m_acc;
            rh_y_reg <= {sq_a_reg, {FRAC_W{1'b0}}} + m_acc;
        end
        if (emitting)
        begin
            out_dir_reg     <= emit_dir;
            out_fingers_reg <= latched_reg;
            out_cmd_reg     <= emit_cmd;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_cmd_reg, out_fingers_reg, out_dir_reg};

    // ------------------------------------------------------------------
    // checks
    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg <= PC_DECIDE))
        else $error("sequencer ran past the end of the program");

    a_emit_at_decide: assert property (@(posedge clk) disable iff (!rst_n)
        emitting |-> ((pc_reg == PC_CHECK) || (pc_reg == PC_DECIDE)))
        else $error("result produced outside a deciding step");

    a_busy_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(s_tvalid && s_tready && (s_tuser == OP_END)))
        else $error("sequencer started without a gesture end word");

    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !emitting)
        else $error("result register overwritten while waiting");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the swipe direction classifier
// Streams begin, update and end words into the block. A tracker mirrors the
// saturating motion sums and the end-of-swipe classification, and checks each
// result word in order. Phases cover default, extreme and random settings,
// with random idling on both sides, one long receiver hold-off and pauses.
// ----------------------------------------------------------------------------
module testbench;
    import swd_pkg::*;

    localparam int SUM_W          = 24;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 500;
    localparam int STALL_LIMIT    = 4000;
    localparam int PAUSE_EVERY    = 120;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // One predicted classification
    typedef struct packed {
        logic [DIR_W-1:0]    dir;
        logic [FINGER_W-1:0] fingers;
        logic [CMD_W-1:0]    cmd;
    } swipe_t;

    // Mirror of the classifier: sums, latched fingers, settings, outcomes due
    class swipe_tracker;
        logic [THRESH_W-1:0] threshold;
        logic [RATIO_W-1:0]  ratio;
        logic [FINGER_W-1:0] cmd_fingers;
        longint              sum_x;
        longint              sum_y;
        logic [FINGER_W-1:0] held_fingers;
        swipe_t              due_swipes[$];
        int                  errors;
        int                  words;
        int                  swipes;
        int                  with_command;
        int                  clamps;
        int                  oblique_rejects;
        int                  dir_seen[4];

        function new();
            threshold       = THRESH_RST;
            ratio           = RATIO_RST;
            cmd_fingers     = FINGERS_RST;
            sum_x           = 0;
            sum_y           = 0;
            held_fingers    = '0;
            errors          = 0;
            words           = 0;
            swipes          = 0;
            with_command    = 0;
            clamps          = 0;
            oblique_rejects = 0;
            dir_seen        = '{0, 0, 0, 0};
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [THRESH_W-1:0] val);
            case (idx)
                REG_THRESH:  threshold   = val;
                REG_RATIO:   ratio       = val[RATIO_W-1:0];
                REG_FINGERS: cmd_fingers = val[FINGER_W-1:0];
                default:     ;
            endcase
        endfunction

        function longint clamp_sum(longint s);
            longint hi;
            longint lo;
            hi = (longint'(1) << (SUM_W - 1)) - 1;
            lo = -hi - 1;
            if (s > hi)
            begin
                clamps++;
                return hi;
            end
            if (s < lo)
            begin
                clamps++;
                return lo;
            end
            return s;
        endfunction

        function longint unsigned magnitude(longint v);
            return (v < 0) ? longint'(-v) : longint'(v);
        endfunction

        // p wins when 2^16*p*p exceeds 2^16*q*q + ratio*p*q
        function bit outweighs(longint unsigned p, longint unsigned q);
            bit [127:0] wp;
            bit [127:0] wq;
            bit [127:0] wr;
            bit [127:0] lhs;
            bit [127:0] rhs;
            wp  = 128'(p);
            wq  = 128'(q);
            wr  = 128'(ratio);
            lhs = (wp * wp) << FRAC_W;
            rhs = ((wq * wq) << FRAC_W) + wr * wp * wq;
            return lhs > rhs;
        endfunction

        // Advance the mirror by one accepted input word
        function void take_word(logic [OP_W-1:0] op, logic [FINGER_W-1:0] fc,
                                logic signed [DELTA_W-1:0] dx,
                                logic signed [DELTA_W-1:0] dy);
            longint unsigned ax;
            longint unsigned ay;
            bit              hit;
            logic [DIR_W-1:0] dir;
            swipe_t          s;
            hit = 0;
            dir = DIR_UP;
            if (op != OP_UNUSED)
                words++;
            case (op)
                OP_BEGIN:
                begin
                    held_fingers = fc;
                    sum_x        = 0;
                    sum_y        = 0;
                end
                OP_UPDATE:
                begin
                    sum_x = clamp_sum(sum_x + longint'(dx));
                    sum_y = clamp_sum(sum_y + longint'(dy));
                end
                OP_END:
                begin
                    ax = magnitude(sum_x);
                    ay = magnitude(sum_y);
                    if (ax >= threshold && ay >= threshold)
                    begin
                        if (outweighs(ax, ay))
                        begin
                            hit = 1;
                            dir = (sum_x > 0) ? DIR_RIGHT : DIR_LEFT;
                        end
                        else if (outweighs(ay, ax))
                        begin
                            hit = 1;
                            dir = (sum_y > 0) ? DIR_DOWN : DIR_UP;
                        end
                        else
                            oblique_rejects++;
                    end
                    else if (ax > threshold)
                    begin
                        hit = 1;
                        dir = (sum_x > 0) ? DIR_RIGHT : DIR_LEFT;
                    end
                    else if (ay > threshold)
                    begin
                        hit = 1;
                        dir = (sum_y > 0) ? DIR_DOWN : DIR_UP;
                    end
                    sum_x = 0;
                    sum_y = 0;
                    if (hit)
                    begin
                        s.dir     = dir;
                        s.fingers = held_fingers;
                        s.cmd     = (held_fingers == cmd_fingers) ? CMD_BASE + dir : CMD_NONE;
                        due_swipes.push_back(s);
                        swipes++;
                        dir_seen[dir]++;
                        if (s.cmd != CMD_NONE)
                            with_command++;
                    end
                end
                default: ;  // unused op: no effect
            endcase
        endfunction

        // Compare one accepted result word with the oldest prediction
        function void check_swipe(logic [15:0] word);
            swipe_t exp_s;
            swipe_t got;
            got.dir     = word[1:0];
            got.fingers = word[5:2];
            got.cmd     = word[8:6];
            if (due_swipes.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected: dir %0d fingers %0d command %0d",
                         $time, got.dir, got.fingers, got.cmd);
                return;
            end
            exp_s = due_swipes.pop_front();
            if (got.dir !== exp_s.dir)
            begin
                errors++;
                $display("%0t: direction mismatch: expected %0d, actual %0d",
                         $time, exp_s.dir, got.dir);
            end
            if (got.fingers !== exp_s.fingers)
            begin
                errors++;
                $display("%0t: fingers mismatch: expected %0d, actual %0d",
                         $time, exp_s.fingers, got.fingers);
            end
            if (got.cmd !== exp_s.cmd)
            begin
                errors++;
                $display("%0t: command mismatch: expected %0d, actual %0d",
                         $time, exp_s.cmd, got.cmd);
            end
        endfunction

        function int pending();
            return due_swipes.size();
        endfunction

        function void close_out();
            if (due_swipes.size() != 0)
            begin
                errors++;
                $display("%0t: %0d predicted results never arrived, expected %0d, actual none",
                         $time, due_swipes.size(), due_swipes.size());
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [THRESH_W-1:0]  cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [39:0]          s_tdata;  // finger_count[3:0], delta_x[19:4], delta_y[35:20]
    logic [OP_W-1:0]      s_tuser;  // op[1:0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;  // direction[1:0], fingers[5:2], command[8:6]

    swipe_tracker tracker;
    bit           tx_gaps;
    bit           rx_gaps;
    bit           rx_hold_req;
    int           stall_cycles;
    int           next_pause;

    swipe_direction_classifier_top #(.SUM_WIDTH(SUM_W)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_tready    = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (rx_gaps && $urandom_range(0, 7) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge clk);
            end
            else
                m_tready = 1'b1;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_swipe(m_tdata);
    end

    // Watchdog: too long without any word moving ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Offer one input word, with an optional idle burst first
    task automatic send_word(logic [OP_W-1:0] op, logic [FINGER_W-1:0] fc,
                             logic signed [DELTA_W-1:0] dx,
                             logic signed [DELTA_W-1:0] dy);
        @(negedge clk);
        if (tx_gaps && $urandom_range(0, 5) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {4'b0, dy, dx, fc};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.take_word(op, fc, dx, dy);
    endtask

    // Stop offering and wait until every predicted result is in
    task automatic wait_for_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THRESH_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        tracker.write_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic apply_settings(logic [THRESH_W-1:0] th, logic [RATIO_W-1:0] r,
                                  logic [FINGER_W-1:0] fc);
        write_reg(REG_THRESH, th);
        write_reg(REG_RATIO, {7'b0, r});
        write_reg(REG_FINGERS, {19'b0, fc});
    endtask

    // Random delta over a random range of scales
    function automatic logic signed [DELTA_W-1:0] scaled_delta(int shift);
        logic signed [DELTA_W-1:0] d;
        d = 16'($urandom);
        return d >>> shift;
    endfunction

    // One random gesture, or now and then a stray or broken one
    task automatic random_gesture(int long_odds);
        logic [FINGER_W-1:0]       fc;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        int                        n;
        int                        sx;
        int                        sy;
        int                        yk;
        bit                        long_run;
        // stray words outside a gesture
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 2))
                0:       send_word(OP_UNUSED, 4'($urandom), 16'($urandom), 16'($urandom));
                1:       send_word(OP_UPDATE, 4'($urandom), scaled_delta($urandom_range(0, 15)),
                                   scaled_delta($urandom_range(0, 15)));
                default: send_word(OP_END, 4'($urandom), 16'($urandom), 16'($urandom));
            endcase
            return;
        end
        fc = $urandom_range(0, 1) ? tracker.cmd_fingers : 4'($urandom_range(0, 15));
        send_word(OP_BEGIN, fc, 16'($urandom), 16'($urandom));
        long_run = ($urandom_range(1, long_odds) == 1);
        n  = long_run ? $urandom_range(200, 300) : $urandom_range(0, 6);
        sx = $urandom_range(0, 15);
        sy = $urandom_range(0, 1) ? sx : $urandom_range(0, 15);
        yk = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
        begin
            if (long_run)
            begin
                // steady push in one direction, heading for saturation
                dx = 16'($urandom_range(16384, 32767));
                dy = (yk == 0) ? 16'sd0 : (yk == 1) ? scaled_delta(8)
                                                    : 16'($urandom_range(16384, 32767));
                if (sx[0])
                    dx = -dx;
                if (sy[0])
                    dy = -dy;
            end
            else
            begin
                dx = scaled_delta(sx);
                dy = scaled_delta(sy);
            end
            send_word(OP_UPDATE, 4'($urandom), dx, dy);
            if ($urandom_range(0, 39) == 0)
                send_word(OP_BEGIN, 4'($urandom), 16'($urandom), 16'($urandom));
        end
        // a few gestures are left without an end
        if ($urandom_range(0, 9) != 0)
            send_word(OP_END, 4'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic run_phase(int upto, int long_odds, int hold_at);
        while (tracker.words < upto)
        begin
            random_gesture(long_odds);
            if (hold_at > 0 && tracker.words >= hold_at)
            begin
                rx_hold_req = 1'b1;
                hold_at     = 0;
            end
            if (tracker.words >= next_pause)
            begin
                wait_for_results();
                next_pause = tracker.words + PAUSE_EVERY;
            end
        end
        wait_for_results();
    endtask

    // Main sequence
    initial
    begin
        tracker     = new();
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        tx_gaps     = 1'b1;
        rx_gaps     = 1'b1;
        rx_hold_req = 1'b0;
        next_pause  = PAUSE_EVERY;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words at the default settings
        send_word(OP_UNUSED, 4'd15, -16'sd1, -16'sd1);      // ignored op
        send_word(OP_UPDATE, 4'd9, 16'sd32767, 16'sd0);     // update without begin
        send_word(OP_END, 4'd0, 16'sd0, 16'sd0);            // right, reset fingers
        send_word(OP_END, 4'd0, 16'sd0, 16'sd0);            // sums already cleared
        send_word(OP_BEGIN, 4'd3, 16'sd0, 16'sd0);
        send_word(OP_UPDATE, 4'd0, 16'sd0, -16'sd32768);
        send_word(OP_END, 4'd15, 16'sd0, 16'sd0);           // up with command
        send_word(OP_BEGIN, 4'd15, 16'sd0, 16'sd0);
        send_word(OP_UPDATE, 4'd0, 16'sd0, 16'sd32767);
        send_word(OP_END, 4'd0, 16'sd0, 16'sd0);            // down, no command
        send_word(OP_BEGIN, 4'd3, 16'sd0, 16'sd0);
        send_word(OP_UPDATE, 4'd0, -16'sd32768, 16'sd0);
        send_word(OP_END, 4'd0, 16'sd0, 16'sd0);            // left with command
        send_word(OP_BEGIN, 4'd3, 16'sd0, 16'sd0);
        send_word(OP_UPDATE, 4'd0, 16'sd32767, -16'sd32768);
        send_word(OP_END, 4'd0, 16'sd0, 16'sd0);            // diagonal, rejected
        send_word(OP_BEGIN, 4'd3, 16'sd0, 16'sd0);
        send_word(OP_UPDATE, 4'd0, 16'sd32767, 16'sd25600);
        send_word(OP_END, 4'd0, 16'sd0, 16'sd0);            // ratio test picks right
        send_word(OP_BEGIN, 4'd0, 16'sd0, 16'sd0);
        send_word(OP_UPDATE, 4'd0, 16'sd25600, 16'sd0);
        send_word(OP_END, 4'd0, 16'sd0, 16'sd0);            // exactly on threshold
        run_phase(360, 60, 200);

        // Low extremes; zero sums must still give nothing
        apply_settings(23'd0, 16'd0, 4'd0);
        send_word(OP_BEGIN, 4'd0, 16'sd0, 16'sd0);
        send_word(OP_END, 4'd0, 16'sd0, 16'sd0);
        run_phase(690, 60, 0);

        // High extremes; negative saturation just beats the top threshold
        apply_settings(23'h7FFFFF, 16'hFFFF, 4'd15);
        tx_gaps = 1'b0;
        send_word(OP_BEGIN, 4'd15, 16'sd0, 16'sd0);
        for (int i = 0; i < 260; i++)
            send_word(OP_UPDATE, 4'd0, -16'sd32768, 16'sd0);
        send_word(OP_END, 4'd0, 16'sd0, 16'sd0);
        tx_gaps = 1'b1;
        run_phase(1100, 6, 0);

        // Small random threshold
        apply_settings(23'($urandom_range(0, 3000)), 16'($urandom), 4'($urandom));
        run_phase(1400, 60, 0);

        // Typical threshold, no idling on either side
        apply_settings(23'($urandom_range(1000, 80000)), 16'($urandom), 4'($urandom));
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        run_phase(1600, 60, 0);

        tracker.close_out();
        $display("Covered %0d input words and %0d swipes (up %0d, down %0d, left %0d, right %0d),",
                 tracker.words, tracker.swipes, tracker.dir_seen[DIR_UP],
                 tracker.dir_seen[DIR_DOWN], tracker.dir_seen[DIR_LEFT],
                 tracker.dir_seen[DIR_RIGHT]);
        $display("%0d with a command, %0d clamped sums, %0d diagonal rejects, 5 settings.",
                 tracker.with_command, tracker.clamps, tracker.oblique_rejects);
        if (tracker.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
